// ===== design/dml_pkg.sv =====
// ----------------------------------------------------------------------------
// Door motor limit controller package
// Shared types, codes and reset values for the door motor limit controller.
// ----------------------------------------------------------------------------
package dml_pkg;

  localparam int unsigned CounterWidthDefault = 16;

  // Configuration register reset values.
  localparam logic [15:0] RunTimeoutReset    = 16'd2500;
  localparam logic [3:0]  DebounceLimitReset = 4'd3;
  localparam logic [15:0] OpenFallbackReset  = 16'd1000;
  localparam logic        OpenFbEnableReset  = 1'b0;

  // APB address decode.
  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned PdataWidth = 32;

  typedef enum logic [1:0] {
    REG_RUN_TIMEOUT    = 2'd0,
    REG_DEBOUNCE_LIMIT = 2'd1,
    REG_OPEN_FB_LIMIT  = 2'd2,
    REG_OPEN_FB_ENABLE = 2'd3
  } reg_idx_e;

  // Request codes on the command field.
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_STANDBY = 3'd1,
    CMD_OPEN    = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_PWRUP   = 3'd4
  } cmd_e;

  // Door mode, one-hot internally.
  typedef enum logic [3:0] {
    MODE_STANDBY = 4'b0001,
    MODE_OPENING = 4'b0010,
    MODE_CLOSING = 4'b0100,
    MODE_PWRUP   = 4'b1000
  } mode_e;

  // Encoded door mode as reported on the result.
  localparam logic [1:0] DOOR_STANDBY = 2'd0;
  localparam logic [1:0] DOOR_OPENING = 2'd1;
  localparam logic [1:0] DOOR_CLOSING = 2'd2;
  localparam logic [1:0] DOOR_PWRUP   = 2'd3;

  // H-bridge drive codes.
  localparam logic [1:0] DRIVE_OFF   = 2'd0;
  localparam logic [1:0] DRIVE_OPEN  = 2'd1;
  localparam logic [1:0] DRIVE_CLOSE = 2'd2;
  localparam logic [1:0] DRIVE_BRAKE = 2'd3;

  typedef struct packed {
    logic [15:0] run_timeout;
    logic [3:0]  debounce_limit;
    logic [15:0] open_fallback_limit;
    logic        open_fallback_enable;
  } cfg_t;

  function automatic logic [1:0] encode_mode(mode_e mode);
    logic [1:0] code;
    case (mode)
      MODE_STANDBY: code = DOOR_STANDBY;
      MODE_OPENING: code = DOOR_OPENING;
      MODE_CLOSING: code = DOOR_CLOSING;
      MODE_PWRUP:   code = DOOR_PWRUP;
      default:      code = DOOR_STANDBY;
    endcase
    return code;
  endfunction

endpackage

// ===== design/dml_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Door motor limit controller configuration registers
// APB-style register file holding the timeout, debounce and fallback settings.
// ----------------------------------------------------------------------------
module dml_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dml_pkg::PaddrWidth-1:0] paddr,
  input  logic [dml_pkg::PdataWidth-1:0] pwdata,
  output logic [dml_pkg::PdataWidth-1:0] prdata,
  output logic                          pready,
  output dml_pkg::cfg_t                 cfg_o
);
  import dml_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_timeout          <= RunTimeoutReset;
      cfg_q.debounce_limit       <= DebounceLimitReset;
      cfg_q.open_fallback_limit  <= OpenFallbackReset;
      cfg_q.open_fallback_enable <= OpenFbEnableReset;
    end else if (wr_en) begin
      case (idx)
        REG_RUN_TIMEOUT:    cfg_q.run_timeout          <= pwdata[15:0];
        REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit       <= pwdata[3:0];
        REG_OPEN_FB_LIMIT:  cfg_q.open_fallback_limit  <= pwdata[15:0];
        REG_OPEN_FB_ENABLE: cfg_q.open_fallback_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RUN_TIMEOUT:    prdata = {16'd0, cfg_q.run_timeout};
      REG_DEBOUNCE_LIMIT: prdata = {28'd0, cfg_q.debounce_limit};
      REG_OPEN_FB_LIMIT:  prdata = {16'd0, cfg_q.open_fallback_limit};
      REG_OPEN_FB_ENABLE: prdata = {31'd0, cfg_q.open_fallback_enable};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/dml_step.sv =====
// ----------------------------------------------------------------------------
// Door motor limit controller step logic
// Door mode, run-time, debounce and fallback state with the per-tick update.
// ----------------------------------------------------------------------------
module dml_step #(
  parameter int unsigned CounterWidth = dml_pkg::CounterWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dml_pkg::cfg_t cfg_i,
  input  logic [2:0]    command_i,
  input  logic          closed_switch_n_i,
  input  logic          opened_switch_n_i,
  output logic [1:0]    motor_drive_o,
  output logic [1:0]    door_mode_o
);
  import dml_pkg::*;

  localparam int unsigned CmpWidth = (CounterWidth > 16) ? CounterWidth : 16;

  mode_e                   mode_q, mode_d;
  logic [CounterWidth-1:0] run_q, run_d;
  logic [CounterWidth-1:0] elapsed_q, elapsed_d;
  logic [3:0]              cdeb_q, cdeb_d;
  logic [3:0]              odeb_q, odeb_d;
  logic [1:0]              drive;

  always_comb begin
    logic  closed_act;
    logic  opened_act;
    logic  hit;
    mode_e mode;

    closed_act = !closed_switch_n_i;
    opened_act = !opened_switch_n_i;
    run_d      = run_q;
    elapsed_d  = elapsed_q;
    cdeb_d     = cdeb_q;
    odeb_d     = odeb_q;
    hit        = 1'b0;

    case (cmd_e'(command_i))
      CMD_STANDBY: mode = MODE_STANDBY;
      CMD_OPEN:    mode = MODE_OPENING;
      CMD_CLOSE:   mode = MODE_CLOSING;
      CMD_PWRUP:   mode = MODE_PWRUP;
      default:     mode = mode_q;
    endcase

    // Timeout check; power-up closing never times out of its mode.
    if (CmpWidth'(run_q) > CmpWidth'(cfg_i.run_timeout)) begin
      run_d = '0;
      if (mode == MODE_CLOSING) begin
        mode = MODE_STANDBY;
      end else if (mode == MODE_OPENING) begin
        mode = MODE_CLOSING;
      end
    end

    case (mode)
      MODE_STANDBY: begin
        elapsed_d = '0;
        run_d     = '0;
        drive     = DRIVE_OFF;
      end
      MODE_OPENING: begin
        if (opened_act) begin
          if (odeb_q >= cfg_i.debounce_limit) begin
            hit = 1'b1;
          end else begin
            odeb_d = odeb_q + 4'd1;
          end
        end else if (odeb_q != 4'd0) begin
          odeb_d = odeb_q - 4'd1;
        end
        // Timed fallback runs only while the open switch is inactive.
        if (!opened_act && cfg_i.open_fallback_enable) begin
          if (CmpWidth'(elapsed_q) < CmpWidth'(cfg_i.open_fallback_limit)) begin
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + CounterWidth'(1);
            end
          end else begin
            hit = 1'b1;
          end
        end
        if (hit) begin
          drive = DRIVE_BRAKE;
          mode  = MODE_CLOSING;
          run_d = '0;
        end else begin
          drive = DRIVE_OPEN;
          if (run_d != '1) begin
            run_d = run_d + CounterWidth'(1);
          end
        end
      end
      default: begin
        elapsed_d = '0;
        if (closed_act) begin
          if (cdeb_q >= cfg_i.debounce_limit) begin
            hit = 1'b1;
          end else begin
            cdeb_d = cdeb_q + 4'd1;
          end
        end else if (cdeb_q != 4'd0) begin
          cdeb_d = cdeb_q - 4'd1;
        end
        if (hit) begin
          drive = DRIVE_BRAKE;
          mode  = MODE_STANDBY;
          run_d = '0;
        end else begin
          drive = DRIVE_CLOSE;
          if (run_d != '1) begin
            run_d = run_d + CounterWidth'(1);
          end
        end
      end
    endcase

    mode_d = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STANDBY;
      run_q     <= '0;
      elapsed_q <= '0;
      cdeb_q    <= '0;
      odeb_q    <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      run_q     <= run_d;
      elapsed_q <= elapsed_d;
      cdeb_q    <= cdeb_d;
      odeb_q    <= odeb_d;
    end
  end

  assign motor_drive_o = drive;
  assign door_mode_o   = encode_mode(mode_d);

endmodule

// ===== design/door_motor_limit_controller_core.sv =====
// ----------------------------------------------------------------------------
// Door motor limit controller core
// Per-tick door motor control with limit switch debounce and run timeout.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input is captured in the input register, then its state
// update is captured in the result register, which holds while out_ready_i is low.
// Throughput: one transaction per cycle while out_ready_i takes each result, set by
// the combinational state update between the two registers.
// Reset: rst_ni clears the door state, counters and pipeline valids, and loads
// the configuration registers with their default values.
module door_motor_limit_controller_core #(
  parameter int unsigned CounterWidth = dml_pkg::CounterWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dml_pkg::PaddrWidth-1:0] paddr,
  input  logic [dml_pkg::PdataWidth-1:0] pwdata,
  output logic [dml_pkg::PdataWidth-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    command_i,
  input  logic                          closed_switch_n_i,
  input  logic                          opened_switch_n_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    motor_drive_o,
  output logic [1:0]                    door_mode_o
);
  import dml_pkg::*;

  cfg_t       cfg;
  logic       in_vld_q;
  logic [2:0] cmd_q;
  logic       closed_n_q;
  logic       opened_n_q;
  logic       out_vld_q;
  logic [1:0] drive_q;
  logic [1:0] mode_q;
  logic       advance;
  logic [1:0] drive_nx;
  logic [1:0] mode_nx;

  // The registered transaction moves on whenever the result register frees up.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  dml_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dml_step #(
    .CounterWidth (CounterWidth)
  ) u_step (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (advance),
    .cfg_i             (cfg),
    .command_i         (cmd_q),
    .closed_switch_n_i (closed_n_q),
    .opened_switch_n_i (opened_n_q),
    .motor_drive_o     (drive_nx),
    .door_mode_o       (mode_nx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q      <= command_i;
      closed_n_q <= closed_switch_n_i;
      opened_n_q <= opened_switch_n_i;
    end
    if (advance) begin
      drive_q <= drive_nx;
      mode_q  <= mode_nx;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign motor_drive_o = drive_q;
  assign door_mode_o   = mode_q;

endmodule
